// ===== hdl/tdr_pkg.sv =====
// Shared constants, codes and pipeline stage types for the ternary digit reassembly block.
package tdr_pkg;

  localparam int DIGIT_STEPS = 31;
  localparam int FRAC_BITS   = 48;
  localparam int IN_BITS     = 48;
  localparam int Y_W         = 64;

  localparam int X_W   = FRAC_BITS + 1;
  localparam int F_W   = FRAC_BITS + 2;
  localparam int F_LO_W = F_W / 2;
  localparam int F_HI_W = F_W - F_LO_W;
  localparam int P_W   = 62;
  localparam int P_LO_W = 31;
  localparam int P_HI_W = P_W - P_LO_W;
  localparam int W_W   = 33;
  localparam int PP_W  = P_W + W_W;
  localparam int PROD_W = F_W + P_W;
  localparam int TERM_SHIFT = FRAC_BITS - 10;
  localparam int Q_W   = PROD_W - TERM_SHIFT;
  localparam int IDX_W = (DIGIT_STEPS > 1) ? $clog2(DIGIT_STEPS) : 1;

  localparam logic [P_W-1:0] POW_CAP = P_W'(1) << 61;
  localparam logic [Y_W-1:0] SIGN64  = Y_W'(1) << 63;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(1);
  localparam logic [31:0] WEIGHT_RST = 32'h2000_0000;

  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_REFLECT = 2'd1;
  localparam logic [1:0] MODE_ZIGZAG  = 2'd2;

  typedef struct packed {
    logic           v;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] acc;
    logic           ovf;
  } link_t;

  typedef struct packed {
    logic           v;
    logic [X_W-1:0] x;
    logic [F_W-1:0] f;
    logic           f_neg;
    logic [Y_W-1:0] acc;
    logic           ovf;
  } dig_t;

  typedef struct packed {
    logic                     v;
    logic [X_W-1:0]           x;
    logic [F_LO_W+P_LO_W-1:0] ll;
    logic [F_LO_W+P_HI_W-1:0] lh;
    logic [F_HI_W+P_LO_W-1:0] hl;
    logic [F_HI_W+P_HI_W-1:0] hh;
    logic                     t_neg;
    logic [Y_W-1:0]           acc;
    logic                     ovf;
  } pp_t;

  typedef struct packed {
    logic           v;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] term;
    logic           huge;
    logic           t_neg;
    logic [Y_W-1:0] acc;
    logic           ovf;
  } trm_t;

endpackage

// ===== hdl/tdr_in_if.sv =====
// Input channel carrying one fraction x per transaction.
interface tdr_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdr_pkg::IN_BITS-1:0]  x_frac;
  modport source (output valid, output x_frac, input ready);
  modport sink (input valid, input x_frac, output ready);
endinterface

// ===== hdl/tdr_out_if.sv =====
// Output channel carrying one reassembled value per transaction.
interface tdr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [tdr_pkg::Y_W-1:0]  y_value;
  logic                            overflow;
  modport source (output valid, output y_value, output overflow, input ready);
  modport sink (input valid, input y_value, input overflow, output ready);
endinterface

// ===== hdl/ternary_digit_reassembly.sv =====
// Ternary digit reassembly: pipelined generalized Cantor function over fixed-point fractions.
//
// Each digit step is four register stages (digit and advance, partial products, term
// rounding, saturating accumulate), and one transaction is accepted every cycle while the
// output is taken and the power table is not being rebuilt. A stalled output freezes the
// whole pipeline. The weight powers w^n sit in a register table that a shared 31x33
// multiplier rebuilds after reset and after each weight write, during which the input
// is not ready.
module ternary_digit_reassembly (
  input  logic                               clk,
  input  logic                               rst,
  tdr_in_if.sink                             in_ch,
  tdr_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [tdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_MULLO = 2'd1;
  localparam logic [1:0] PH_MULHI = 2'd2;
  localparam logic [1:0] PH_FIN   = 2'd3;

  localparam int D = tdr_pkg::DIGIT_STEPS;

  logic [31:0]                weight;
  logic [1:0]                 mode;
  logic                       busy;
  logic [1:0]                 phase;
  logic [tdr_pkg::IDX_W-1:0]  idx;
  logic [tdr_pkg::P_W-1:0]    cur_pow;
  logic [tdr_pkg::P_W-1:0]    pw [D];
  logic [63:0]                plo;
  logic [63:0]                phi;
  logic [63:0]                pmul;

  logic                       w_neg;
  logic [tdr_pkg::W_W-1:0]    w_mag;
  logic [tdr_pkg::PP_W-1:0]   pprod;
  logic [tdr_pkg::PP_W-1:0]   pround;
  logic [tdr_pkg::P_W-1:0]    pow_next;

  logic                       en;
  tdr_pkg::link_t             head;
  tdr_pkg::link_t             lnk [D];

  assign w_neg = weight[31];
  assign w_mag = w_neg ? ({1'b0, ~weight} + tdr_pkg::W_W'(1)) : {1'b0, weight};

  assign pmul = 64'((phase == PH_MULLO) ? cur_pow[tdr_pkg::P_LO_W-1:0]
                                         : cur_pow[tdr_pkg::P_W-1:tdr_pkg::P_LO_W])
              * 64'(w_mag);

  always_comb begin
    pprod  = (tdr_pkg::PP_W'(phi) << tdr_pkg::P_LO_W) + tdr_pkg::PP_W'(plo);
    pround = (pprod + (tdr_pkg::PP_W'(1) << 29)) >> 30;
    if (pround > tdr_pkg::PP_W'(tdr_pkg::POW_CAP)) begin
      pow_next = tdr_pkg::POW_CAP;
    end else begin
      pow_next = pround[tdr_pkg::P_W-1:0];
    end
  end

  // Config registers and power table sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= tdr_pkg::WEIGHT_RST;
      mode   <= tdr_pkg::MODE_PLAIN;
      busy   <= 1'b1;
      phase  <= PH_START;
      idx    <= '0;
    end else begin
      if (busy) begin
        case (phase)
          PH_START: begin
            idx   <= tdr_pkg::IDX_W'(1);
            phase <= PH_MULLO;
            if (D == 1) begin
              busy <= 1'b0;
            end
          end
          PH_MULLO: phase <= PH_MULHI;
          PH_MULHI: phase <= PH_FIN;
          PH_FIN: begin
            if (idx == tdr_pkg::IDX_W'(D - 1)) begin
              busy <= 1'b0;
            end else begin
              idx   <= idx + tdr_pkg::IDX_W'(1);
              phase <= PH_MULLO;
            end
          end
          default: phase <= PH_START;
        endcase
      end
      if (cfg_we) begin
        if (cfg_index == tdr_pkg::CFG_WEIGHT) begin
          weight <= cfg_data[31:0];
          busy   <= 1'b1;
          phase  <= PH_START;
          idx    <= '0;
        end else if (cfg_index == tdr_pkg::CFG_MODE) begin
          mode <= cfg_data[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      case (phase)
        PH_START: begin
          cur_pow <= tdr_pkg::P_W'(w_mag);
          pw[0]   <= tdr_pkg::P_W'(w_mag);
        end
        PH_MULLO: plo <= pmul;
        PH_MULHI: phi <= pmul;
        PH_FIN: begin
          cur_pow <= pow_next;
          pw[idx] <= pow_next;
        end
        default: cur_pow <= cur_pow;
      endcase
    end
  end

  // Datapath
  assign en          = !lnk[D-1].v || out_ch.ready;
  assign in_ch.ready = en && !busy;

  always_comb begin
    head.v   = in_ch.valid && in_ch.ready;
    head.x   = tdr_pkg::X_W'(((tdr_pkg::X_W + tdr_pkg::IN_BITS)'(in_ch.x_frac)
                << tdr_pkg::FRAC_BITS) >> tdr_pkg::IN_BITS);
    head.acc = tdr_pkg::SIGN64;
    head.ovf = 1'b0;
  end

  for (genvar k = 0; k < D; k++) begin : g_step
    localparam logic P_EVEN = ((k % 2) == 0);
    localparam logic [tdr_pkg::F_W-1:0] ONE = tdr_pkg::F_W'(1) << tdr_pkg::FRAC_BITS;

    tdr_pkg::link_t stin;
    tdr_pkg::dig_t  s1, n1;
    tdr_pkg::pp_t   s2, n2;
    tdr_pkg::trm_t  s3, n3;
    tdr_pkg::link_t n4;

    logic [tdr_pkg::F_W-1:0]    t3;
    logic [tdr_pkg::F_W-1:0]    xn;
    logic [tdr_pkg::F_W-1:0]    x2;
    logic [1:0]                 dig;
    logic [tdr_pkg::PROD_W-1:0] prod;
    logic [tdr_pkg::Q_W-1:0]    q;
    logic [tdr_pkg::Y_W:0]      sum;

    if (k == 0) begin : g_first
      assign stin = head;
    end else begin : g_next
      assign stin = lnk[k-1];
    end

    always_comb begin
      t3 = tdr_pkg::F_W'(stin.x) + (tdr_pkg::F_W'(stin.x) << 1);
      if (t3 < ONE) begin
        dig = 2'd0;
      end else if (t3 < (ONE << 1)) begin
        dig = 2'd1;
      end else begin
        dig = 2'd2;
      end
      if (mode == tdr_pkg::MODE_REFLECT && dig == 2'd1) begin
        xn = (ONE << 1) - t3;
      end else if (dig == 2'd0) begin
        xn = t3;
      end else if (dig == 2'd1) begin
        xn = t3 - ONE;
      end else begin
        xn = t3 - (ONE << 1);
      end
      x2       = xn << 1;
      n1.v     = stin.v;
      n1.x     = tdr_pkg::X_W'(xn);
      n1.acc   = stin.acc;
      n1.ovf   = stin.ovf;
      n1.f_neg = 1'b0;
      if (mode == tdr_pkg::MODE_ZIGZAG) begin
        if (dig == 2'd0) begin
          n1.f = xn;
        end else if (dig == 2'd1) begin
          if (x2 > ONE) begin
            n1.f_neg = 1'b1;
            n1.f     = x2 - ONE;
          end else begin
            n1.f = ONE - x2;
          end
        end else begin
          n1.f_neg = 1'b1;
          n1.f     = ONE - xn;
        end
      end else if (dig == 2'd0) begin
        n1.f = '0;
      end else if (dig == 2'd1) begin
        n1.f = ONE;
      end else begin
        n1.f = ONE << 1;
      end
    end

    always_comb begin
      n2.v     = s1.v;
      n2.x     = s1.x;
      n2.acc   = s1.acc;
      n2.ovf   = s1.ovf;
      n2.t_neg = s1.f_neg ^ (w_neg & P_EVEN);
      n2.ll    = (tdr_pkg::F_LO_W + tdr_pkg::P_LO_W)'(s1.f[tdr_pkg::F_LO_W-1:0])
               * (tdr_pkg::F_LO_W + tdr_pkg::P_LO_W)'(pw[k][tdr_pkg::P_LO_W-1:0]);
      n2.lh    = (tdr_pkg::F_LO_W + tdr_pkg::P_HI_W)'(s1.f[tdr_pkg::F_LO_W-1:0])
               * (tdr_pkg::F_LO_W + tdr_pkg::P_HI_W)'(pw[k][tdr_pkg::P_W-1:tdr_pkg::P_LO_W]);
      n2.hl    = (tdr_pkg::F_HI_W + tdr_pkg::P_LO_W)'(s1.f[tdr_pkg::F_W-1:tdr_pkg::F_LO_W])
               * (tdr_pkg::F_HI_W + tdr_pkg::P_LO_W)'(pw[k][tdr_pkg::P_LO_W-1:0]);
      n2.hh    = (tdr_pkg::F_HI_W + tdr_pkg::P_HI_W)'(s1.f[tdr_pkg::F_W-1:tdr_pkg::F_LO_W])
               * (tdr_pkg::F_HI_W + tdr_pkg::P_HI_W)'(pw[k][tdr_pkg::P_W-1:tdr_pkg::P_LO_W]);
    end

    always_comb begin
      prod = (tdr_pkg::PROD_W'(s2.hh) << (tdr_pkg::F_LO_W + tdr_pkg::P_LO_W))
           + (tdr_pkg::PROD_W'(s2.hl) << tdr_pkg::F_LO_W)
           + (tdr_pkg::PROD_W'(s2.lh) << tdr_pkg::P_LO_W)
           + tdr_pkg::PROD_W'(s2.ll)
           + (tdr_pkg::PROD_W'(1) << (tdr_pkg::TERM_SHIFT - 1));
      q        = tdr_pkg::Q_W'(prod >> tdr_pkg::TERM_SHIFT);
      n3.v     = s2.v;
      n3.x     = s2.x;
      n3.acc   = s2.acc;
      n3.ovf   = s2.ovf;
      n3.t_neg = s2.t_neg;
      n3.term  = q[tdr_pkg::Y_W-1:0];
      n3.huge  = |q[tdr_pkg::Q_W-1:tdr_pkg::Y_W];
    end

    always_comb begin
      n4.v = s3.v;
      n4.x = s3.x;
      if (s3.t_neg) begin
        sum = {1'b0, s3.acc} - {1'b0, s3.term};
      end else begin
        sum = {1'b0, s3.acc} + {1'b0, s3.term};
      end
      if (s3.huge || sum[tdr_pkg::Y_W]) begin
        n4.acc = s3.t_neg ? '0 : '1;
        n4.ovf = 1'b1;
      end else begin
        n4.acc = sum[tdr_pkg::Y_W-1:0];
        n4.ovf = s3.ovf;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s1.v     <= 1'b0;
        s2.v     <= 1'b0;
        s3.v     <= 1'b0;
        lnk[k].v <= 1'b0;
      end else if (en) begin
        s1     <= n1;
        s2     <= n2;
        s3     <= n3;
        lnk[k] <= n4;
      end
    end
  end

  assign out_ch.valid    = lnk[D-1].v;
  assign out_ch.y_value  = $signed(lnk[D-1].acc ^ tdr_pkg::SIGN64);
  assign out_ch.overflow = lnk[D-1].ovf;

  a_weight_rebuild: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == tdr_pkg::CFG_WEIGHT) |=> (busy && !in_ch.ready))
    else $error("weight write did not start a power table rebuild");

  a_pow_capped: assert property (@(posedge clk) disable iff (rst)
    (busy && phase == PH_FIN) |=> (cur_pow <= tdr_pkg::POW_CAP))
    else $error("weight power exceeds cap");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= tdr_pkg::IDX_W'(D - 1)))
    else $error("power table index out of range");

  a_rebuild_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(idx) == tdr_pkg::IDX_W'(D - 1) || D == 1))
    else $error("power table rebuild ended early");

endmodule
